/* sv/ctw_pkg.sv */
// Shared types and constants of the census transform window core.
package ctw_pkg;

  localparam int COORD_W    = 6;
  localparam int PIX_W      = 8;
  localparam int CENSUS_W   = 63;
  localparam int SIZE_W     = 7;
  localparam int HH_W       = 2;
  localparam int HW_W       = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;

  localparam int DEF_MAX_ROWS        = 64;
  localparam int DEF_MAX_COLS        = 64;
  localparam int DEF_MAX_HALF_HEIGHT = 3;
  localparam int DEF_MAX_HALF_WIDTH  = 4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 8'd3;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
  } in_item_t;

  typedef struct packed {
    logic [CENSUS_W-1:0] census_bits;
    logic [COORD_W-1:0]  out_row;
    logic [COORD_W-1:0]  out_col;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [HH_W-1:0]   hh;
    logic [HW_W-1:0]   hw;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic               kind;
    logic               in_frame;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] cr;
    logic [COORD_W-1:0] cc;
    logic [PIX_W-1:0]   pixel;
  } job_t;

endpackage

/* sv/ctw_ram.sv */
// Generic single-port RAM with registered read data.
module ctw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/ctw_front.sv */
// Front end: accepts items, checks writes against the frame and wraps query centres.
module ctw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ctw_pkg::in_item_t in_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctw_pkg::cfg_t     cfg,
  output ctw_pkg::job_t     job,
  output logic              job_valid,
  input  logic              job_ready
);
  import ctw_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic                inf_r, inf_nxt;
  logic [SIZE_W-1:0]   rrem_r, rrem_nxt, crem_r, crem_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [2:0]          idx;
  logic [SIZE_W-1:0]   rtry, ctry;

  assign idx  = 3'(COORD_W - 1) - step_r;
  assign rtry = {rrem_r[SIZE_W-2:0], item_r.row[idx]};
  assign ctry = {crem_r[SIZE_W-2:0], item_r.col[idx]};

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    inf_nxt   = inf_r;
    rrem_nxt  = rrem_r;
    crem_nxt  = crem_r;
    step_nxt  = step_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          inf_nxt  = ({1'b0, in_data.row} < cfg.rows) && ({1'b0, in_data.col} < cfg.cols);
          rrem_nxt = '0;
          crem_nxt = '0;
          step_nxt = '0;
          state_nxt = (in_data.kind == KIND_QUERY) ? F_MOD : F_PUSH;
        end
      end
      F_MOD: begin
        // Restoring remainder, one coordinate bit per cycle for row and column.
        rrem_nxt = (rtry >= cfg.rows) ? rtry - cfg.rows : rtry;
        crem_nxt = (ctry >= cfg.cols) ? ctry - cfg.cols : ctry;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(COORD_W - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    item_r <= item_nxt;
    inf_r  <= inf_nxt;
    rrem_r <= rrem_nxt;
    crem_r <= crem_nxt;
    step_r <= step_nxt;
  end

  assign in_ready     = (state_r == F_IDLE);
  assign job_valid    = (state_r == F_PUSH);
  assign job.kind     = item_r.kind;
  assign job.in_frame = inf_r;
  assign job.row      = item_r.row;
  assign job.col      = item_r.col;
  assign job.cr       = rrem_r[COORD_W-1:0];
  assign job.cc       = crem_r[COORD_W-1:0];
  assign job.pixel    = item_r.pixel;

`ifndef SYNTHESIS
  a_centre_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job.kind == KIND_QUERY |->
      ({1'b0, job.cr} < cfg.rows) && ({1'b0, job.cc} < cfg.cols))
    else $error("query centre not reduced into the frame");
`endif

endmodule

/* sv/ctw_queue.sv */
// Two-entry queue between the front end and the back end.
module ctw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  ctw_pkg::job_t in_job,
  input  logic          in_valid,
  output logic          in_ready,
  output ctw_pkg::job_t out_job,
  output logic          out_valid,
  input  logic          out_ready
);
  import ctw_pkg::*;

  job_t       entries_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = entries_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      entries_r[wp_r] <= in_job;
    end
  end

endmodule

/* sv/ctw_back.sv */
// Back end: performs pixel writes and walks the census window for queries.
module ctw_back #(
  parameter int MAX_COLS = ctw_pkg::DEF_MAX_COLS,
  parameter int AW       = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctw_pkg::job_t             job,
  input  logic                      job_valid,
  output logic                      job_ready,
  input  ctw_pkg::cfg_t             cfg,
  output logic                      ram_we,
  output logic [AW-1:0]             ram_addr,
  output logic [ctw_pkg::PIX_W-1:0] ram_wdata,
  input  logic [ctw_pkg::PIX_W-1:0] ram_rdata,
  output ctw_pkg::out_item_t        out_data,
  output logic                      out_valid,
  input  logic                      out_ready
);
  import ctw_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_PREP  = 5'b00010,
    B_SCAN  = 5'b00100,
    B_DRAIN = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  logic [COORD_W-1:0]   y_r, y_nxt, x_r, x_nxt, xs_r, xs_nxt;
  logic [COORD_W-1:0]   row_r, row_nxt, col_r, col_nxt;
  logic [2:0]           i_r, i_nxt, k_r, k_nxt;
  logic [3:0]           j_r, j_nxt;
  logic [5:0]           bit_r, bit_nxt, pbit_r, pbit_nxt;
  logic                 pend_r, pend_nxt, cen_pend_r, cen_pend_nxt;
  logic [PIX_W-1:0]     centre_r, centre_nxt;
  logic [CENSUS_W-1:0]  vec_r, vec_nxt;
  out_item_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]   rows_m1, cols_m1;

  function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] r,
                                            input logic [COORD_W-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  assign rows_m1 = COORD_W'(cfg.rows - 7'd1);
  assign cols_m1 = COORD_W'(cfg.cols - 7'd1);

  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    x_nxt         = x_r;
    xs_nxt        = xs_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    bit_nxt       = bit_r;
    pbit_nxt      = pbit_r;
    pend_nxt      = 1'b0;
    cen_pend_nxt  = 1'b0;
    centre_nxt    = centre_r;
    vec_nxt       = vec_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_addr      = addr_of(y_r, x_r);
    ram_wdata     = job.pixel;

    if (cen_pend_r) begin
      centre_nxt = ram_rdata;
    end
    // Read data arrives in the cycle after its address, so the compare uses the delayed bit index.
    if (pend_r && (centre_r > ram_rdata)) begin
      vec_nxt[pbit_r] = 1'b1;
    end

    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          if (job.kind == KIND_WRITE) begin
            ram_we   = job.in_frame;
            ram_addr = addr_of(job.row, job.col);
          end else begin
            ram_addr     = addr_of(job.cr, job.cc);
            cen_pend_nxt = 1'b1;
            y_nxt        = job.cr;
            x_nxt        = job.cc;
            row_nxt      = job.row;
            col_nxt      = job.col;
            k_nxt        = '0;
            i_nxt        = '0;
            j_nxt        = '0;
            bit_nxt      = '0;
            vec_nxt      = '0;
            state_nxt    = B_PREP;
          end
        end
      end
      B_PREP: begin
        // Step back from the centre to the top left corner, wrapping at the frame edge.
        if ((k_r >= {1'b0, cfg.hh}) && (k_r >= cfg.hw)) begin
          xs_nxt    = x_r;
          state_nxt = B_SCAN;
        end else begin
          if (k_r < {1'b0, cfg.hh}) begin
            y_nxt = (y_r == '0) ? rows_m1 : y_r - 1'b1;
          end
          if (k_r < cfg.hw) begin
            x_nxt = (x_r == '0) ? cols_m1 : x_r - 1'b1;
          end
          k_nxt = k_r + 3'd1;
        end
      end
      B_SCAN: begin
        pend_nxt = 1'b1;
        pbit_nxt = bit_r;
        bit_nxt  = bit_r + 6'd1;
        if (j_r == {cfg.hw, 1'b0}) begin
          j_nxt = '0;
          x_nxt = xs_r;
          y_nxt = (y_r == rows_m1) ? '0 : y_r + 1'b1;
          if (i_r == {cfg.hh, 1'b0}) begin
            state_nxt = B_DRAIN;
          end else begin
            i_nxt = i_r + 3'd1;
          end
        end else begin
          j_nxt = j_r + 4'd1;
          x_nxt = (x_r == cols_m1) ? '0 : x_r + 1'b1;
        end
      end
      B_DRAIN: begin
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.census_bits = vec_r;
          out_nxt.out_row     = row_r;
          out_nxt.out_col     = col_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_r      <= 1'b0;
      cen_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cen_pend_r  <= cen_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    y_r      <= y_nxt;
    x_r      <= x_nxt;
    xs_r     <= xs_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    bit_r    <= bit_nxt;
    pbit_r   <= pbit_nxt;
    centre_r <= centre_nxt;
    vec_r    <= vec_nxt;
    out_r    <= out_nxt;
  end

  assign job_ready = (state_r == B_IDLE);
  assign out_data  = out_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == B_IDLE)
    else $error("frame write while a query owns the memory port");
  a_compare_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == B_SCAN))
    else $error("neighbour compare without a preceding window read");
  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_SCAN |-> (j_r <= {cfg.hw, 1'b0}) && (i_r <= {1'b0, cfg.hh, 1'b0}))
    else $error("window position outside the configured window");
`endif

endmodule

/* sv/census_transform_window_core.sv */
// Top level of the census transform window core.
//
// The core stores a grey frame of up to MAX_ROWS x MAX_COLS pixels in a single-port RAM
// and answers census queries on it. For a query, the front end wraps the centre
// coordinates into the frame, and the back end steps back to the window corner and then
// scans the window, reading one neighbour per cycle from the single memory port. A front
// end and the memory back end are separated by a two-entry queue, and results leave
// through an output register. Configuration writes are taken at any time and should be
// made only while the core is idle; the frame memory is not cleared by reset.
module census_transform_window_core #(
  parameter int MAX_ROWS        = ctw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS        = ctw_pkg::DEF_MAX_COLS,
  parameter int MAX_HALF_HEIGHT = ctw_pkg::DEF_MAX_HALF_HEIGHT,
  parameter int MAX_HALF_WIDTH  = ctw_pkg::DEF_MAX_HALF_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctw_pkg::in_item_t              in_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  output ctw_pkg::out_item_t             out_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctw_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RST_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int RST_COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int RST_HH   = (MAX_HALF_HEIGHT < 1) ? MAX_HALF_HEIGHT : 1;
  localparam int RST_HW   = (MAX_HALF_WIDTH < 1) ? MAX_HALF_WIDTH : 1;

  cfg_t              cfg_r, cfg_nxt;
  job_t              f_job, q_job;
  logic              f_valid, f_ready, q_valid, q_ready;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;
  logic [SIZE_W-1:0] size_v;
  logic [HH_W-1:0]   hh_v;
  logic [HW_W-1:0]   hw_v;

  assign cfg_ready = 1'b1;
  assign size_v    = cfg_data[SIZE_W-1:0];
  assign hh_v      = cfg_data[HH_W-1:0];
  assign hw_v      = cfg_data[HW_W-1:0];

  // Sizes saturate into 1..MAX and radii into 0..MAX when written.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_ROWS: begin
          cfg_nxt.rows = (size_v == '0) ? SIZE_W'(1) :
                         (int'(size_v) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : size_v;
        end
        CFG_FRAME_COLS: begin
          cfg_nxt.cols = (size_v == '0) ? SIZE_W'(1) :
                         (int'(size_v) > MAX_COLS) ? SIZE_W'(MAX_COLS) : size_v;
        end
        CFG_HALF_HEIGHT: begin
          cfg_nxt.hh = (int'(hh_v) > MAX_HALF_HEIGHT) ? HH_W'(MAX_HALF_HEIGHT) : hh_v;
        end
        CFG_HALF_WIDTH: begin
          cfg_nxt.hw = (int'(hw_v) > MAX_HALF_WIDTH) ? HW_W'(MAX_HALF_WIDTH) : hw_v;
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows <= SIZE_W'(RST_ROWS);
      cfg_r.cols <= SIZE_W'(RST_COLS);
      cfg_r.hh   <= HH_W'(RST_HH);
      cfg_r.hw   <= HW_W'(RST_HW);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ctw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg       (cfg_r),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  ctw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_job    (f_job),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_job   (q_job),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  ctw_back #(
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .cfg       (cfg_r),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  ctw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench of the census transform window core.
module tb;
  import ctw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LOAD_DIM = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  in_item_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  out_item_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  census_transform_window_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the frame and the window settings.
  logic [PIX_W-1:0] frame_px [DEF_MAX_ROWS*DEF_MAX_COLS];
  int unsigned frame_rows = 64;
  int unsigned frame_cols = 64;
  int unsigned half_h = 1;
  int unsigned half_w = 1;

  out_item_t census_q[$];
  int errors = 0;
  int n_writes = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int unsigned cycles = 0;
  bit no_idle = 1'b0;
  int hold_cycles = 0;
  int stall_left = 0;

  function automatic logic [CENSUS_W-1:0] predict_census(int unsigned row, int unsigned col);
    int unsigned cr, cc, wd, yr, xc, b;
    logic [PIX_W-1:0] centre;
    logic [CENSUS_W-1:0] v;
    v = '0;
    cr = row % frame_rows;
    cc = col % frame_cols;
    centre = frame_px[cr*DEF_MAX_COLS + cc];
    wd = 2*half_w + 1;
    for (int unsigned i = 0; i <= 2*half_h; i++) begin
      yr = (cr + i + 8*frame_rows - half_h) % frame_rows;
      for (int unsigned j = 0; j < wd; j++) begin
        xc = (cc + j + 8*frame_cols - half_w) % frame_cols;
        b = i*wd + j;
        if (b < CENSUS_W && centre > frame_px[yr*DEF_MAX_COLS + xc]) v[b] = 1'b1;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result checker: every output transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (census_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_item = census_q.pop_front();
        n_checked++;
        if (out_data.census_bits !== exp_item.census_bits) begin
          $display("%0t: census_bits expected %h actual %h", $time,
                   exp_item.census_bits, out_data.census_bits);
          errors++;
        end
        if (out_data.out_row !== exp_item.out_row) begin
          $display("%0t: out_row expected %0d actual %0d", $time,
                   exp_item.out_row, out_data.out_row);
          errors++;
        end
        if (out_data.out_col !== exp_item.out_col) begin
          $display("%0t: out_col expected %0d actual %0d", $time,
                   exp_item.out_col, out_data.out_col);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic kind, input int unsigned row, input int unsigned col,
                           input int unsigned pix);
    in_item_t it;
    out_item_t res;
    it.kind = kind;
    it.row = row[COORD_W-1:0];
    it.col = col[COORD_W-1:0];
    it.pixel = pix[PIX_W-1:0];
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (it.kind == KIND_WRITE) begin
      n_writes++;
      if (it.row < frame_rows && it.col < frame_cols)
        frame_px[it.row*DEF_MAX_COLS + it.col] = it.pixel;
    end else begin
      n_queries++;
      res.census_bits = predict_census(it.row, it.col);
      res.out_row = it.row;
      res.out_col = it.col;
      census_q.push_back(res);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (census_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes are made only when the core has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] d;
    d = val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    case (idx)
      CFG_FRAME_ROWS: frame_rows = (d == 0) ? 1 : (d > DEF_MAX_ROWS) ? DEF_MAX_ROWS : d;
      CFG_FRAME_COLS: frame_cols = (d == 0) ? 1 : (d > DEF_MAX_COLS) ? DEF_MAX_COLS : d;
      CFG_HALF_HEIGHT: half_h = (d[HH_W-1:0] > DEF_MAX_HALF_HEIGHT) ?
                                DEF_MAX_HALF_HEIGHT : d[HH_W-1:0];
      CFG_HALF_WIDTH: half_w = (d[HW_W-1:0] > DEF_MAX_HALF_WIDTH) ?
                               DEF_MAX_HALF_WIDTH : d[HW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(input int unsigned r, input int unsigned c,
                            input int unsigned hh, input int unsigned hw);
    wait_drain();
    write_reg(CFG_FRAME_ROWS, r);
    write_reg(CFG_FRAME_COLS, c);
    write_reg(CFG_HALF_HEIGHT, hh);
    write_reg(CFG_HALF_WIDTH, hw);
  endtask

  function automatic int unsigned rand_pixel();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 255 : 0;
      1: return 100 + $urandom_range(0, 2);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Loads the top left LOAD_DIM x LOAD_DIM block, all of row 0 and all of column 0.
  // Every later frame is either inside that block, one row high or one column wide,
  // so no query ever reads an unwritten pixel.
  task automatic test_frame_load();
    for (int r = 0; r < LOAD_DIM; r++)
      for (int c = 0; c < LOAD_DIM; c++)
        send_item(KIND_WRITE, r, c, rand_pixel());
    for (int k = LOAD_DIM; k < DEF_MAX_COLS; k++)
      send_item(KIND_WRITE, 0, k, rand_pixel());
    for (int k = LOAD_DIM; k < DEF_MAX_ROWS; k++)
      send_item(KIND_WRITE, k, 0, rand_pixel());
  endtask

  task automatic test_directed();
    set_window(LOAD_DIM, LOAD_DIM, 1, 1);
    send_item(KIND_QUERY, 0, 0, 0);
    send_item(KIND_QUERY, 63, 63, 255);
    stop_sending();
    set_window(LOAD_DIM, LOAD_DIM, 3, 7);
    send_item(KIND_WRITE, 20, 20, 255);
    send_item(KIND_WRITE, 21, 21, 0);
    send_item(KIND_QUERY, 20, 20, 0);
    send_item(KIND_QUERY, 21, 21, 0);
    send_item(KIND_QUERY, 0, 63, 0);
    stop_sending();
    set_window(5, 3, 2, 4);
    send_item(KIND_WRITE, 10, 1, 255);
    send_item(KIND_WRITE, 1, 40, 255);
    send_item(KIND_WRITE, 2, 1, 200);
    send_item(KIND_QUERY, 2, 1, 0);
    send_item(KIND_QUERY, 63, 63, 0);
    stop_sending();
    set_window(0, 127, 3, 4);
    send_item(KIND_QUERY, 0, 5, 0);
    send_item(KIND_QUERY, 33, 62, 0);
    stop_sending();
    set_window(2, 1, 0, 0);
    send_item(KIND_QUERY, 1, 0, 0);
    send_item(KIND_QUERY, 42, 17, 0);
    stop_sending();
    wait_drain();
    write_reg(8'd4, 7'h55);
    write_reg(8'd255, 7'h2a);
    write_reg(CFG_HALF_WIDTH, 5);
    write_reg(CFG_HALF_WIDTH, 6);
    send_item(KIND_QUERY, 1, 0, 0);
    stop_sending();
  endtask

  task automatic random_items(input int count);
    int unsigned r, c;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
      end else begin
        r = $urandom_range(0, frame_rows - 1);
        c = $urandom_range(0, frame_cols - 1);
      end
      send_item(($urandom_range(0, 9) < 6) ? KIND_QUERY : KIND_WRITE, r, c, rand_pixel());
    end
    stop_sending();
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_window(LOAD_DIM, LOAD_DIM, 3, 4);
        1: set_window(1, 1, 3, 4);
        2: set_window(64, 1, 0, 4);
        3: set_window(1, 64, 3, 0);
        default: set_window($urandom_range(0, LOAD_DIM), $urandom_range(0, LOAD_DIM),
                            $urandom_range(0, 3), $urandom_range(0, 7));
      endcase
      random_items(90);
    end
  endtask

  // The receiver stops for a long stretch so that the core fills and stalls its input.
  task automatic test_backpressure();
    set_window(16, 16, 3, 4);
    hold_cycles = 600;
    random_items(40);
  endtask

  task automatic test_no_idle();
    set_window(LOAD_DIM, 20, 2, 3);
    no_idle = 1'b1;
    random_items(100);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_frame_load();
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    wait_drain();
    $display("Covered %0d pixel writes, %0d census queries (%0d results checked)",
             n_writes, n_queries, n_checked);
    $display("over %0d register writes, incl. tiny frames, wrap and saturated settings.", n_cfg);
    if (errors == 0 && census_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* census_transform_window_core.f */
sv/ctw_pkg.sv
sv/ctw_ram.sv
sv/ctw_front.sv
sv/ctw_queue.sv
sv/ctw_back.sv
sv/census_transform_window_core.sv
dv/tb.sv
